[hw/rtl/call_frame_memory_manager_macros.svh]
// Assertion helpers used by call_frame_memory_manager.sv.
`ifndef CALL_FRAME_MEMORY_MANAGER_MACROS_SVH
`define CALL_FRAME_MEMORY_MANAGER_MACROS_SVH

// Same-cycle implication, held off during reset
`define CFM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define CFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/cfm_pkg.sv]
`timescale 1ns / 1ps

package cfm_pkg;

    // Sizes of the store and of one access
    localparam int MEM_BYTES_DEF    = 65536;
    localparam int MAX_ACCESS_BYTES = 8;
    localparam int NUM_BANKS        = 8;
    localparam int BANK_BITS        = 3;
    localparam int ADDR_W           = 16;
    localparam int WIDE_W           = 17;
    localparam int COUNT_W          = 4;
    localparam int VALUE_W          = 64;
    localparam int STATUS_W         = 2;
    localparam logic [WIDE_W-1:0] CAPACITY_RST = 17'd65536;

    typedef enum logic [2:0] {
        CMD_INIT      = 3'd0,
        CMD_PREPARE   = 3'd1,
        CMD_ENTER     = 3'd2,
        CMD_EXIT      = 3'd3,
        CMD_WRITE_ABS = 3'd4,
        CMD_READ_ABS  = 3'd5,
        CMD_READ_REL  = 3'd6,
        CMD_QUERY     = 3'd7
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK  = 2'd0,
        ST_OVF = 2'd1,
        ST_OOB = 2'd2
    } t_status;

    // Item held while the bank reads complete
    typedef struct packed {
        logic                 rd_en;
        logic [BANK_BITS-1:0] lo;
        logic [COUNT_W-1:0]   count;
        logic [WIDE_W-1:0]    result_address;
        logic [ADDR_W-1:0]    prev_base;
        logic [ADDR_W-1:0]    prev_end;
        t_status              status;
    } t_stage;

endpackage

[hw/rtl/cfm_ram.sv]
`timescale 1ns / 1ps

module cfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, registered read; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/call_frame_memory_manager.sv]
`timescale 1ns / 1ps
// An input beat is registered in the stage register and the byte-bank read, then moved into the output register.
// A new item is not accepted until the previous one has moved into the output register.
// The next item is accepted while a finished result still waits in the output register.
// Reset (synchronous, active low): frame base and end to zero, capacity to 65536,
// pipeline empty, both readies low while reset is held. Byte store is not cleared.
module call_frame_memory_manager #(
    parameter int MEM_BYTES = cfm_pkg::MEM_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cfm_pkg::WIDE_W-1:0]       i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [2:0]                       i_command,
    input  logic [cfm_pkg::ADDR_W-1:0]       i_address,
    input  logic [cfm_pkg::ADDR_W-1:0]       i_offset,
    input  logic [cfm_pkg::ADDR_W-1:0]       i_frame_size,
    input  logic [cfm_pkg::COUNT_W-1:0]      i_byte_count,
    input  logic [cfm_pkg::VALUE_W-1:0]      i_write_value,
    input  logic [cfm_pkg::ADDR_W-1:0]       i_saved_base,
    input  logic [cfm_pkg::ADDR_W-1:0]       i_saved_end,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [cfm_pkg::VALUE_W-1:0]      o_read_value,
    output logic [cfm_pkg::WIDE_W-1:0]       o_result_address,
    output logic [cfm_pkg::ADDR_W-1:0]       o_prior_base,
    output logic [cfm_pkg::ADDR_W-1:0]       o_prior_end,
    output logic [cfm_pkg::STATUS_W-1:0]     o_status
);

    import cfm_pkg::*;

`include "call_frame_memory_manager_macros.svh"

    localparam int ROWS = (MEM_BYTES + NUM_BANKS - 1) / NUM_BANKS;
    localparam int RW   = $clog2(ROWS);

    // Registers
    logic [WIDE_W-1:0]  r_capacity;
    logic [ADDR_W-1:0]  r_base, n_base;
    logic [ADDR_W-1:0]  r_end, n_end;
    logic               r_busy;
    t_stage             r_stg, n_stg;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_read_value, n_read_value;
    logic [WIDE_W-1:0]  r_result_address;
    logic [ADDR_W-1:0]  r_prior_base, r_prior_end;
    t_status            r_status;

    logic               in_beat, out_move;
    logic [WIDE_W-1:0]  bound;
    logic [WIDE_W-1:0]  acc_addr;
    logic [WIDE_W:0]    acc_top;
    logic [WIDE_W-1:0]  size_sum;
    logic               acc_ok;
    logic               do_write;
    logic [7:0]         bank_rdata [NUM_BANKS];
    logic [NUM_BANKS-1:0] bank_we;

    assign o_cfg_ready = i_rst_n;
    assign o_in_ready  = i_rst_n && !r_busy;
    assign in_beat     = i_in_valid && o_in_ready;
    assign out_move    = r_busy && (!r_out_valid || i_out_ready);

    // Effective bound: min(capacity, MEM_BYTES)
    assign bound = (32'(r_capacity) < 32'(MEM_BYTES)) ? r_capacity : WIDE_W'(MEM_BYTES);

    // Access address and bounds check
    assign acc_addr = ((t_cmd'(i_command) == CMD_READ_REL) ? {1'b0, r_base}
                                                            : {1'b0, i_address})
                    + {1'b0, i_offset};
    assign acc_top  = {1'b0, acc_addr} + (WIDE_W + 1)'(i_byte_count);
    assign acc_ok   = (i_byte_count <= COUNT_W'(MAX_ACCESS_BYTES))
                   && (acc_top <= {1'b0, bound});
    assign do_write = in_beat && (t_cmd'(i_command) == CMD_WRITE_ABS) && acc_ok;

    // Command decode: frame update and result fields known at accept time
    always_comb begin
        n_base   = r_base;
        n_end    = r_end;
        size_sum = '0;
        n_stg    = '{rd_en: 1'b0, lo: acc_addr[BANK_BITS-1:0], count: i_byte_count,
                     result_address: '0, prev_base: '0, prev_end: '0, status: ST_OK};
        unique case (t_cmd'(i_command))
            CMD_INIT: begin
                n_base = i_address;
                n_end  = i_address;
            end
            CMD_PREPARE: begin
                size_sum = {1'b0, r_end} + {1'b0, i_frame_size};
                n_stg.result_address = {1'b0, r_end};
                if (size_sum >= bound) begin
                    n_stg.status = ST_OVF;
                end
            end
            CMD_ENTER: begin
                size_sum = {1'b0, i_address} + {1'b0, i_frame_size};
                n_stg.prev_base = r_base;
                n_stg.prev_end  = r_end;
                if (size_sum >= bound) begin
                    n_stg.status         = ST_OVF;
                    n_stg.result_address = '1;
                end else begin
                    n_base = i_address;
                    n_end  = size_sum[ADDR_W-1:0];
                    n_stg.result_address = {1'b0, i_address};
                end
            end
            CMD_EXIT: begin
                n_base = i_saved_base;
                n_end  = i_saved_end;
            end
            CMD_WRITE_ABS: begin
                if (!acc_ok) begin
                    n_stg.status = ST_OOB;
                end
            end
            CMD_READ_ABS, CMD_READ_REL: begin
                if (!acc_ok) begin
                    n_stg.status = ST_OOB;
                end else begin
                    n_stg.rd_en = 1'b1;
                end
            end
            CMD_QUERY: begin
                n_stg.result_address = {1'b0, r_base} + {1'b0, i_offset};
            end
            default: begin
            end
        endcase
    end

    // Eight interleaved byte banks: byte at addr lives in bank addr%8, row addr/8
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        logic [BANK_BITS-1:0] lane;
        logic [WIDE_W-1:0]    row_wide;

        assign lane         = BANK_BITS'(b) - acc_addr[BANK_BITS-1:0];
        assign row_wide     = (acc_addr >> BANK_BITS)
                            + ((BANK_BITS'(b) < acc_addr[BANK_BITS-1:0]) ? 17'd1 : 17'd0);
        assign bank_we[b]   = do_write && ({1'b0, lane} < i_byte_count);

        cfm_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_en    (in_beat),
            .i_we    (bank_we[b]),
            .i_addr  (RW'(row_wide)),
            .i_wdata (i_write_value[8*lane +: 8]),
            .o_rdata (bank_rdata[b])
        );
    end

    // Reassemble read bytes, little-endian, masked to the count
    always_comb begin
        logic [BANK_BITS-1:0] src;
        n_read_value = '0;
        for (int i = 0; i < NUM_BANKS; i++) begin
            src = r_stg.lo + BANK_BITS'(i);
            if (r_stg.rd_en && (COUNT_W'(i) < r_stg.count)) begin
                n_read_value[8*i +: 8] = bank_rdata[src];
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAPACITY_RST;
            r_base      <= '0;
            r_end       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            if (in_beat) begin
                r_base <= n_base;
                r_end  <= n_end;
            end
            if (in_beat) begin
                r_busy <= 1'b1;
            end else if (out_move) begin
                r_busy <= 1'b0;
            end
            if (out_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_stg <= n_stg;
        end
        if (out_move) begin
            r_read_value     <= n_read_value;
            r_result_address <= r_stg.result_address;
            r_prior_base     <= r_stg.prev_base;
            r_prior_end      <= r_stg.prev_end;
            r_status         <= r_stg.status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_value     = r_read_value;
    assign o_result_address = r_result_address;
    assign o_prior_base     = r_prior_base;
    assign o_prior_end      = r_prior_end;
    assign o_status         = r_status;

    // Checks
    `CFM_ASSERT_NEXT(a_accept_fills, in_beat, r_busy, "accepted beat did not fill the stage")
    `CFM_ASSERT_NOW(a_no_write_busy, r_busy, bank_we == '0, "bank write while stage busy")
    `CFM_ASSERT_NOW(a_oob_zero, r_out_valid && (r_status == ST_OOB), r_read_value == '0,
        "out-of-bounds result carries read data")
    `CFM_ASSERT_NEXT(a_refused_enter,
        in_beat && (t_cmd'(i_command) == CMD_ENTER) && (n_stg.status == ST_OVF),
        $stable(r_base) && $stable(r_end), "refused enter changed the frame")

endmodule
